@@ hw/rtl/bls_pkg.sv @@
// Shared types and constants for the Bresenham line stepper.
`default_nettype none

package bls_pkg;

    // Internal coordinate width; coordinates wrap within this many bits.
    localparam int COORD_BITS = 16;

    // Fixed widths of the port fields.
    localparam int PORT_COORD_BITS = 16;
    localparam int COLOR_BITS      = 8;
    localparam int CFG_BITS        = 16;
    localparam int APB_DATA_BITS   = 32;
    localparam int APB_ADDR_BITS   = 3;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic [COORD_BITS:0]        err_t;
    typedef logic [PORT_COORD_BITS-1:0] port_coord_t;
    typedef logic [COLOR_BITS-1:0]      color_t;
    typedef logic [CFG_BITS-1:0]        cfg_t;
    typedef logic [APB_DATA_BITS-1:0]   apb_data_t;

    localparam cfg_t FRAME_WIDTH_RESET  = cfg_t'(1024);
    localparam cfg_t FRAME_HEIGHT_RESET = cfg_t'(768);

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } action_t;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    // One classified command as it travels from the front to the back.
    typedef struct packed {
        action_t kind;
        coord_t  x0;
        coord_t  y0;
        coord_t  major_delta;
        coord_t  minor_delta;
        logic    major_is_x;
        logic    x_down;
        logic    y_down;
        color_t  color;
    } line_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/bls_in_if.sv @@
// Command channel interface of the line stepper.
`default_nettype none

interface bls_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 action;
    logic [bls_pkg::PORT_COORD_BITS-1:0]  start_x;
    logic [bls_pkg::PORT_COORD_BITS-1:0]  start_y;
    logic [bls_pkg::PORT_COORD_BITS-1:0]  end_x;
    logic [bls_pkg::PORT_COORD_BITS-1:0]  end_y;
    logic [bls_pkg::COLOR_BITS-1:0]       pen_color;

    modport source (
        output valid, action, start_x, start_y, end_x, end_y, pen_color,
        input  ready
    );

    modport sink (
        input  valid, action, start_x, start_y, end_x, end_y, pen_color,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/bls_out_if.sv @@
// Pixel channel interface of the line stepper.
`default_nettype none

interface bls_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [bls_pkg::PORT_COORD_BITS-1:0]  pixel_x;
    logic [bls_pkg::PORT_COORD_BITS-1:0]  pixel_y;
    logic [bls_pkg::COLOR_BITS-1:0]       pixel_color;
    logic                                 last_pixel;
    logic                                 in_frame;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_pixel, in_frame,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_pixel, in_frame,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/bresenham_line_stepper_top.sv @@
// Top level of the Bresenham line stepper: configuration registers and datapath.
`default_nettype none

// Bresenham line rasterizer. A command with action 0 (start) latches two
// endpoints and a pen color and sets up a line; it produces no pixel. Each
// command with action 1 (step) then produces one pixel transfer carrying the
// current coordinates, the color, a last-pixel flag and an in-frame flag
// (x below frame_width and y below frame_height). A line from A to B yields
// max(|dx|,|dy|)+1 pixels, A first and B last; after the last one the block
// is idle and further steps are consumed without producing anything. A start
// in the middle of a line abandons the old line. Commands are accepted into
// a four-entry queue whenever it has room, so a new command can be taken in
// every cycle while earlier ones are still being worked on. The stepping
// engine takes one command per clock: one accumulator add and compare plus
// the coordinate increments per pixel, so the sustained rate is one pixel per
// cycle as long as the pixel sink keeps ready high. When nothing is queued
// ahead of a step command and the output register is free, the step's transfer
// writes it into the queue, and from there its pixel is loaded into the output
// register, where it appears on the output. Frame width and height are set
// over the APB port at byte addresses 0 and 4; they reset to 1024 and 768
// and should only be written while no pixels are pending.

module bresenham_line_stepper_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    bls_in_if.sink                                 cmd,
    bls_out_if.source                              pix,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bls_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire bls_pkg::apb_data_t                pwdata,
    output bls_pkg::apb_data_t                     prdata,
    output logic                                   pready
);

    bls_pkg::cfg_t       frame_width_reg,  frame_width_next;
    bls_pkg::cfg_t       frame_height_reg, frame_height_next;
    bls_pkg::reg_index_t reg_sel;
    logic                cfg_write;

    logic                q_push;
    bls_pkg::line_cmd_t  q_push_entry;
    logic                q_full;
    logic                q_pop;
    bls_pkg::line_cmd_t  q_pop_entry;
    logic                q_empty;

    // The register is chosen by word address; the two low address bits are ignored.
    assign reg_sel   = bls_pkg::reg_index_t'(paddr[2]);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_write)
        begin
            case (reg_sel)
                bls_pkg::REG_FRAME_WIDTH:  frame_width_next  = pwdata[bls_pkg::CFG_BITS-1:0];
                bls_pkg::REG_FRAME_HEIGHT: frame_height_next = pwdata[bls_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            bls_pkg::REG_FRAME_WIDTH:  prdata = bls_pkg::apb_data_t'(frame_width_reg);
            bls_pkg::REG_FRAME_HEIGHT: prdata = bls_pkg::apb_data_t'(frame_height_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bls_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= bls_pkg::FRAME_HEIGHT_RESET;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    // Front end: takes commands and works out deltas, directions and major axis.
    bls_front u_front (
        .cmd        (cmd),
        .queue_full (q_full),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    // Queue that lets the front keep accepting while the engine waits on the sink.
    bls_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_pop_entry),
        .empty      (q_empty)
    );

    // Stepping engine with its output register.
    bls_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry        (q_pop_entry),
        .empty        (q_empty),
        .pop          (q_pop),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pix          (pix)
    );

endmodule

`default_nettype wire

@@ hw/rtl/bls_front.sv @@
// Front end: accepts commands and turns start commands into line setup.
`default_nettype none

module bls_front (
    bls_in_if.sink              cmd,
    input  wire logic           queue_full,
    output logic                push,
    output bls_pkg::line_cmd_t  push_entry
);

    bls_pkg::coord_t x1;
    bls_pkg::coord_t y1;
    bls_pkg::coord_t x2;
    bls_pkg::coord_t y2;
    bls_pkg::coord_t dx;
    bls_pkg::coord_t dy;
    logic            x_down;
    logic            y_down;
    logic            major_is_x;

    assign cmd.ready = !queue_full;
    assign push      = cmd.valid && !queue_full;

    always_comb
    begin
        x1 = bls_pkg::coord_t'(cmd.start_x);
        y1 = bls_pkg::coord_t'(cmd.start_y);
        x2 = bls_pkg::coord_t'(cmd.end_x);
        y2 = bls_pkg::coord_t'(cmd.end_y);

        x_down     = x2 < x1;
        y_down     = y2 < y1;
        dx         = x_down ? (x1 - x2) : (x2 - x1);
        dy         = y_down ? (y1 - y2) : (y2 - y1);
        major_is_x = dx >= dy;

        push_entry.kind        = bls_pkg::action_t'(cmd.action);
        push_entry.x0          = x1;
        push_entry.y0          = y1;
        push_entry.major_delta = major_is_x ? dx : dy;
        push_entry.minor_delta = major_is_x ? dy : dx;
        push_entry.major_is_x  = major_is_x;
        push_entry.x_down      = x_down;
        push_entry.y_down      = y_down;
        push_entry.color       = cmd.pen_color;
    end

endmodule

`default_nettype wire

@@ hw/rtl/bls_queue.sv @@
// Short command queue between the front end and the stepping engine.
`default_nettype none

module bls_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire bls_pkg::line_cmd_t  push_entry,
    output logic                     full,
    input  wire logic                pop,
    output bls_pkg::line_cmd_t       pop_entry,
    output logic                     empty
);

    bls_pkg::line_cmd_t              mem_reg [bls_pkg::QUEUE_DEPTH];
    logic [bls_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [bls_pkg::QPTR_BITS-1:0]   wr_ptr_next;
    logic [bls_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [bls_pkg::QPTR_BITS-1:0]   rd_ptr_next;
    logic [bls_pkg::QPTR_BITS:0]     count_reg;
    logic [bls_pkg::QPTR_BITS:0]     count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full      = count_reg == (bls_pkg::QPTR_BITS+1)'(bls_pkg::QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign pop_entry = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bls_back.sv @@
// Stepping engine: holds the line state and emits one pixel per step command while a line is in progress.
`default_nettype none

module bls_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bls_pkg::line_cmd_t  entry,
    input  wire logic                empty,
    output logic                     pop,
    input  wire bls_pkg::cfg_t       frame_width,
    input  wire bls_pkg::cfg_t       frame_height,
    bls_out_if.source                pix
);

    bls_pkg::coord_t  cur_x_reg,       cur_x_next;
    bls_pkg::coord_t  cur_y_reg,       cur_y_next;
    bls_pkg::err_t    err_acc_reg,     err_acc_next;
    bls_pkg::coord_t  major_delta_reg, major_delta_next;
    bls_pkg::coord_t  minor_delta_reg, minor_delta_next;
    bls_pkg::coord_t  pixels_left_reg, pixels_left_next;
    logic             major_is_x_reg,  major_is_x_next;
    logic             x_down_reg,      x_down_next;
    logic             y_down_reg,      y_down_next;
    bls_pkg::color_t  line_color_reg,  line_color_next;
    logic             busy_reg,        busy_next;

    logic                 out_valid_reg, out_valid_next;
    bls_pkg::port_coord_t out_x_reg,     out_x_next;
    bls_pkg::port_coord_t out_y_reg,     out_y_next;
    bls_pkg::color_t      out_color_reg, out_color_next;
    logic                 out_last_reg,  out_last_next;
    logic                 out_frame_reg, out_frame_next;

    logic                 is_start;
    logic                 out_free;
    logic                 emit;
    logic                 last;
    bls_pkg::err_t        err_sum;
    bls_pkg::err_t        major_ext;
    logic                 step_minor;
    bls_pkg::port_coord_t cur_x_port;
    bls_pkg::port_coord_t cur_y_port;

    assign is_start = entry.kind == bls_pkg::ACT_START;
    assign out_free = !out_valid_reg || pix.ready;
    // A start, or a step with no line in progress, never needs the output.
    assign pop      = !empty && (is_start || !busy_reg || out_free);
    assign emit     = pop && !is_start && busy_reg;
    assign last     = pixels_left_reg == '0;

    assign major_ext  = {1'b0, major_delta_reg};
    assign err_sum    = err_acc_reg + {1'b0, minor_delta_reg};
    assign step_minor = err_sum >= major_ext;
    assign cur_x_port = bls_pkg::port_coord_t'(cur_x_reg);
    assign cur_y_port = bls_pkg::port_coord_t'(cur_y_reg);

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        err_acc_next     = err_acc_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        pixels_left_next = pixels_left_reg;
        major_is_x_next  = major_is_x_reg;
        x_down_next      = x_down_reg;
        y_down_next      = y_down_reg;
        line_color_next  = line_color_reg;
        busy_next        = busy_reg;

        out_valid_next = out_valid_reg && !pix.ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;
        out_frame_next = out_frame_reg;

        if (pop && is_start)
        begin
            cur_x_next       = entry.x0;
            cur_y_next       = entry.y0;
            err_acc_next     = bls_pkg::err_t'(entry.major_delta >> 1);
            major_delta_next = entry.major_delta;
            minor_delta_next = entry.minor_delta;
            pixels_left_next = entry.major_delta;
            major_is_x_next  = entry.major_is_x;
            x_down_next      = entry.x_down;
            y_down_next      = entry.y_down;
            line_color_next  = entry.color;
            busy_next        = 1'b1;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            out_x_next     = cur_x_port;
            out_y_next     = cur_y_port;
            out_color_next = line_color_reg;
            out_last_next  = last;
            out_frame_next = (cur_x_port < frame_width) && (cur_y_port < frame_height);

            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pixels_left_next = pixels_left_reg - 1'b1;
                err_acc_next     = step_minor ? (err_sum - major_ext) : err_sum;
                if (major_is_x_reg)
                begin
                    cur_x_next = x_down_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                    if (step_minor)
                    begin
                        cur_y_next = y_down_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                    end
                end
                else
                begin
                    cur_y_next = y_down_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                    if (step_minor)
                    begin
                        cur_x_next = x_down_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            err_acc_reg     <= '0;
            major_delta_reg <= '0;
            minor_delta_reg <= '0;
            pixels_left_reg <= '0;
            major_is_x_reg  <= 1'b0;
            x_down_reg      <= 1'b0;
            y_down_reg      <= 1'b0;
            line_color_reg  <= '0;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            err_acc_reg     <= err_acc_next;
            major_delta_reg <= major_delta_next;
            minor_delta_reg <= minor_delta_next;
            pixels_left_reg <= pixels_left_next;
            major_is_x_reg  <= major_is_x_next;
            x_down_reg      <= x_down_next;
            y_down_reg      <= y_down_next;
            line_color_reg  <= line_color_next;
            busy_reg        <= busy_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
        out_frame_reg <= out_frame_next;
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = out_x_reg;
    assign pix.pixel_y     = out_y_reg;
    assign pix.pixel_color = out_color_reg;
    assign pix.last_pixel  = out_last_reg;
    assign pix.in_frame    = out_frame_reg;

`ifndef SYNTHESIS
    // The accumulator stays below the major delta during a line, unless the major delta is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (err_acc_reg < major_ext || major_delta_reg == '0))
        else $error("error accumulator out of range");

    // Emitting the final pixel ends the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last) |=> !busy_reg)
        else $error("line still busy after its last pixel");

    // The final pixel appears on the output flagged as last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last) |=> (pix.valid && pix.last_pixel))
        else $error("last pixel not flagged");

    // A pixel is never loaded over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("output register overwritten");
`endif

endmodule

`default_nettype wire
